// ===== rtl/core/ufx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufx_pkg
// Shared types and constants of the serial ring buffers with XON/XOFF flow
// control: request and result layouts, action and register codes.
// ----------------------------------------------------------------------------
package ufx_pkg;

	localparam int BYTE_W = 8;
	localparam int LEVEL_W = 7;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 7;
	localparam int RX_LEVEL_W = 6;

	localparam logic [BYTE_W-1:0] XON_BYTE = 8'h11;
	localparam logic [BYTE_W-1:0] XOFF_BYTE = 8'h13;

	localparam logic [CFG_INDEX_W-1:0] CFG_FLOW_ENABLE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_STOP_LEVEL = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RESUME_LEVEL = 2'd2;

	localparam logic [LEVEL_W-1:0] STOP_LEVEL_RST = 7'd48;
	localparam logic [LEVEL_W-1:0] RESUME_LEVEL_RST = 7'd16;

	typedef enum logic [1:0] {
		ACT_LINE_RX = 2'd0,
		ACT_HOST_SEND = 2'd1,
		ACT_HOST_READ = 2'd2,
		ACT_LINE_READY = 2'd3
	} action_t;

	typedef struct packed {
		action_t action;
		logic [BYTE_W-1:0] data_byte;
	} item_t;

	typedef struct packed {
		logic line_valid;
		logic [BYTE_W-1:0] line_byte;
		logic host_valid;
		logic [BYTE_W-1:0] host_byte;
		logic accepted;
		logic control_dropped;
		logic send_paused;
		logic [RX_LEVEL_W-1:0] rx_level;
	} result_t;

	typedef struct packed {
		logic push;
		logic pop;
	} rx_cmd_t;

	typedef struct packed {
		logic push_back;
		logic pop;
		logic [1:0] front_count;
		logic front_first_xoff;
	} tx_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/ufx_rx_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufx_rx_queue
// Receive ring buffer: line bytes in at the write pointer, host reads out at
// the read pointer, registered read data, holds at most DEPTH-1 bytes.
// ----------------------------------------------------------------------------
module ufx_rx_queue #(
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ufx_pkg::rx_cmd_t           cmd,
	input  logic [7:0]                 wdata,
	output logic [$clog2(DEPTH)-1:0]   count,
	output logic [7:0]                 rdata
);
	import ufx_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [PW:0] DEPTH_X = (PW + 1)'(DEPTH);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [BYTE_W-1:0] rdata_q;
	logic [PW:0] diff;

	always_comb begin
		if (wp_q >= rp_q) begin
			diff = {1'b0, wp_q} - {1'b0, rp_q};
		end else begin
			diff = ({1'b0, wp_q} + DEPTH_X) - {1'b0, rp_q};
		end
	end

	assign count = diff[PW-1:0];
	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wp_q] <= wdata;
		end
		if (cmd.pop) begin
			rdata_q <= mem[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (cmd.push) begin
				wp_q <= (wp_q == LAST) ? '0 : wp_q + 1'b1;
			end
			if (cmd.pop) begin
				rp_q <= (rp_q == LAST) ? '0 : rp_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ufx_tx_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufx_tx_queue
// Transmit ring buffer with push at the back for host bytes and up to two
// control bytes pushed at the front per item. Storage is split into an even
// bank, an odd bank and a register for the last slot, so the two front slots
// never share a write port. Read data is registered.
// ----------------------------------------------------------------------------
module ufx_tx_queue #(
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ufx_pkg::tx_cmd_t           cmd,
	input  logic [7:0]                 wdata,
	output logic [$clog2(DEPTH)-1:0]   count,
	output logic [7:0]                 rdata
);
	import ufx_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int BD = DEPTH / 2;
	localparam int BW = $clog2(BD);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [PW:0] DEPTH_X = (PW + 1)'(DEPTH);

	typedef enum logic [2:0] {
		SEL_EVEN = 3'b001,
		SEL_ODD = 3'b010,
		SEL_LAST = 3'b100
	} rsel_t;

	logic [BYTE_W-1:0] mem_e [BD];
	logic [BYTE_W-1:0] mem_o [BD];
	logic [BYTE_W-1:0] last_q;
	logic [PW-1:0] wp_q, rp_q;
	logic [PW-1:0] dec1, dec2;
	logic [PW:0] diff;

	logic w_en [3];
	logic [PW-1:0] w_addr [3];
	logic [BYTE_W-1:0] w_data [3];

	logic e_we, o_we, l_we;
	logic [BW-1:0] e_idx, o_idx, r_idx;
	logic [BYTE_W-1:0] e_data, o_data, l_data;
	rsel_t rsel, rsel_q;
	logic [BYTE_W-1:0] rd_e_q, rd_o_q, rd_l_q;

	always_comb begin
		if (wp_q >= rp_q) begin
			diff = {1'b0, wp_q} - {1'b0, rp_q};
		end else begin
			diff = ({1'b0, wp_q} + DEPTH_X) - {1'b0, rp_q};
		end
	end

	assign count = diff[PW-1:0];
	assign dec1 = (rp_q == '0) ? LAST : rp_q - 1'b1;
	assign dec2 = (dec1 == '0) ? LAST : dec1 - 1'b1;

	always_comb begin
		w_en[0] = cmd.push_back;
		w_addr[0] = wp_q;
		w_data[0] = wdata;
		w_en[1] = cmd.front_count != 2'd0;
		w_addr[1] = dec1;
		w_data[1] = cmd.front_first_xoff ? XOFF_BYTE : XON_BYTE;
		w_en[2] = cmd.front_count == 2'd2;
		w_addr[2] = dec2;
		w_data[2] = XON_BYTE;
	end

	always_comb begin
		e_we = 1'b0;
		o_we = 1'b0;
		l_we = 1'b0;
		e_idx = '0;
		o_idx = '0;
		e_data = '0;
		o_data = '0;
		l_data = '0;
		for (int k = 0; k < 3; k++) begin
			if (w_en[k]) begin
				if (w_addr[k] == LAST) begin
					l_we = 1'b1;
					l_data = w_data[k];
				end else if (w_addr[k][0]) begin
					o_we = 1'b1;
					o_idx = BW'(w_addr[k] >> 1);
					o_data = w_data[k];
				end else begin
					e_we = 1'b1;
					e_idx = BW'(w_addr[k] >> 1);
					e_data = w_data[k];
				end
			end
		end
	end

	always_comb begin
		r_idx = BW'(rp_q >> 1);
		if (rp_q == LAST) begin
			rsel = SEL_LAST;
		end else if (rp_q[0]) begin
			rsel = SEL_ODD;
		end else begin
			rsel = SEL_EVEN;
		end
	end

	always_ff @(posedge clk) begin
		if (e_we) begin
			mem_e[e_idx] <= e_data;
		end
		if (o_we) begin
			mem_o[o_idx] <= o_data;
		end
		if (l_we) begin
			last_q <= l_data;
		end
		if (cmd.pop) begin
			rsel_q <= rsel;
			if (rsel == SEL_EVEN) begin
				rd_e_q <= mem_e[r_idx];
			end
			if (rsel == SEL_ODD) begin
				rd_o_q <= mem_o[r_idx];
			end
			if (rsel == SEL_LAST) begin
				rd_l_q <= last_q;
			end
		end
	end

	always_comb begin
		case (rsel_q)
			SEL_EVEN: rdata = rd_e_q;
			SEL_ODD:  rdata = rd_o_q;
			SEL_LAST: rdata = rd_l_q;
			default:  rdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (cmd.push_back) begin
				wp_q <= (wp_q == LAST) ? '0 : wp_q + 1'b1;
			end
			if (cmd.pop) begin
				rp_q <= (rp_q == LAST) ? '0 : rp_q + 1'b1;
			end else if (cmd.front_count == 2'd2) begin
				rp_q <= dec2;
			end else if (cmd.front_count == 2'd1) begin
				rp_q <= dec1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/uart_fifo_xon_xoff.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_fifo_xon_xoff
// Serial receive and transmit ring buffers with XON/XOFF flow control.
// A request passes the request register, then the result register with
// registered queue reads, before its result is offered.
// Throughput: one request per cycle while the result side does not stall;
// the queue pointers update in one pass. Reset clears pointers, flow state
// and registers to defaults; the byte stores are not cleared.
// ----------------------------------------------------------------------------
module uart_fifo_xon_xoff #(
	parameter int RX_DEPTH = 64,
	parameter int TX_DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  ufx_pkg::item_t                      item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output ufx_pkg::result_t                    result,
	input  logic                                cfg_we,
	input  logic [ufx_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ufx_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ufx_pkg::*;

	localparam int RPW = $clog2(RX_DEPTH);
	localparam int TPW = $clog2(TX_DEPTH);
	localparam int CW = (RPW > LEVEL_W) ? RPW : LEVEL_W;
	localparam logic [RPW-1:0] RX_FULL = RPW'(RX_DEPTH - 1);
	localparam logic [TPW-1:0] TX_FULL = TPW'(TX_DEPTH - 1);
	localparam logic [TPW-1:0] TX_NEAR = TPW'(TX_DEPTH - 2);

	logic flow_q;
	logic [LEVEL_W-1:0] stop_q, resume_q;
	logic partner_q, we_allow_q;

	item_t item_s1;
	logic valid_s1;

	logic valid_s2;
	logic line_valid_s2, host_valid_s2, accepted_s2, dropped_s2, paused_s2;
	logic [RX_LEVEL_W-1:0] rx_level_s2;

	logic adv, proc;
	logic is_line, is_send, is_read, is_ready;
	logic [RPW-1:0] rx_count, rx_after;
	logic [TPW-1:0] tx_count;
	logic [BYTE_W-1:0] rx_rdata, tx_rdata;
	logic [CW-1:0] occ;
	logic off_fire, on_fire, we_mid, tx_ok1, tx_ok2;
	logic [1:0] pushed;
	logic dropped, accepted, partner_next;
	rx_cmd_t rx_cmd;
	tx_cmd_t tx_cmd;

	assign adv = !valid_s2 || !result_stall;
	assign proc = valid_s1 && adv;
	assign item_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_q <= 1'b1;
			stop_q <= STOP_LEVEL_RST;
			resume_q <= RESUME_LEVEL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FLOW_ENABLE:  flow_q <= cfg_data[0];
				CFG_STOP_LEVEL:   stop_q <= cfg_data;
				CFG_RESUME_LEVEL: resume_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		is_line = item_s1.action == ACT_LINE_RX;
		is_send = item_s1.action == ACT_HOST_SEND;
		is_read = item_s1.action == ACT_HOST_READ;
		is_ready = item_s1.action == ACT_LINE_READY;
		occ = CW'(rx_count);

		partner_next = partner_q;
		if (is_line && flow_q && item_s1.data_byte == XON_BYTE) begin
			partner_next = 1'b1;
		end
		if (is_line && flow_q && item_s1.data_byte == XOFF_BYTE) begin
			partner_next = 1'b0;
		end

		off_fire = is_line && flow_q && (occ > CW'(stop_q)) && we_allow_q;
		we_mid = we_allow_q && !off_fire;
		on_fire = is_line && flow_q && (occ < CW'(resume_q)) && !we_mid;

		tx_ok1 = tx_count != TX_FULL;
		tx_ok2 = tx_ok1 && tx_count != TX_NEAR;

		if (off_fire && on_fire) begin
			pushed = tx_ok2 ? 2'd2 : (tx_ok1 ? 2'd1 : 2'd0);
		end else begin
			pushed = ((off_fire || on_fire) && tx_ok1) ? 2'd1 : 2'd0;
		end
		dropped = ((off_fire || on_fire) && !tx_ok1) || (off_fire && on_fire && !tx_ok2);

		rx_cmd.push = proc && is_line && rx_count != RX_FULL;
		rx_cmd.pop = proc && is_read && rx_count != '0;

		tx_cmd.push_back = proc && is_send && tx_ok1;
		tx_cmd.pop = proc && is_ready && tx_count != '0 && (!flow_q || partner_q);
		tx_cmd.front_count = proc ? pushed : 2'd0;
		tx_cmd.front_first_xoff = off_fire;

		accepted = (is_line && rx_count != RX_FULL) || (is_send && tx_ok1);

		if (rx_cmd.push) begin
			rx_after = rx_count + 1'b1;
		end else if (rx_cmd.pop) begin
			rx_after = rx_count - 1'b1;
		end else begin
			rx_after = rx_count;
		end
	end

	ufx_rx_queue #(
		.DEPTH (RX_DEPTH)
	) u_rx (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rx_cmd),
		.wdata  (item_s1.data_byte),
		.count  (rx_count),
		.rdata  (rx_rdata)
	);

	ufx_tx_queue #(
		.DEPTH (TX_DEPTH)
	) u_tx (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (tx_cmd),
		.wdata  (item_s1.data_byte),
		.count  (tx_count),
		.rdata  (tx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partner_q <= 1'b1;
			we_allow_q <= 1'b1;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
			if (proc) begin
				partner_q <= partner_next;
				we_allow_q <= we_mid || on_fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (proc) begin
			line_valid_s2 <= tx_cmd.pop;
			host_valid_s2 <= rx_cmd.pop;
			accepted_s2 <= accepted;
			dropped_s2 <= dropped;
			paused_s2 <= flow_q && !partner_next;
			rx_level_s2 <= RX_LEVEL_W'(rx_after);
		end
	end

	assign result_valid = valid_s2;

	always_comb begin
		result.line_valid = line_valid_s2;
		result.line_byte = line_valid_s2 ? tx_rdata : '0;
		result.host_valid = host_valid_s2;
		result.host_byte = host_valid_s2 ? rx_rdata : '0;
		result.accepted = accepted_s2;
		result.control_dropped = dropped_s2;
		result.send_paused = paused_s2;
		result.rx_level = rx_level_s2;
	end

	// no send while the partner holds us off
	a_no_send_paused: assert property (@(posedge clk) disable iff (!arst_n)
		tx_cmd.pop |-> (!flow_q || partner_q))
		else $error("transmit pop while paused");

	// receive queue never overfills
	a_rx_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		rx_cmd.push |-> rx_count != RX_FULL)
		else $error("receive push on full queue");

	// a stored byte never comes with a delivered byte
	a_accept_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.accepted) |-> (!result.line_valid && !result.host_valid))
		else $error("accepted together with a delivery");

	// own flow state only moves on a processed request
	a_we_allow_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!proc |=> $stable(we_allow_q))
		else $error("flow state changed without a request");

endmodule
`default_nettype wire

// ===== bench/uart_fifo_xon_xoff_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_fifo_xon_xoff_checker
// Watches the request, result and register ports of uart_fifo_xon_xoff.
// Keeps its own copy of both ring buffers, the XON/XOFF permission state and
// the register values, predicts the result of each taken request, and checks
// every delivered result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module uart_fifo_xon_xoff_checker
	import ufx_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	input  logic                       item_stall,
	input  item_t                      item,
	input  logic                       result_valid,
	input  logic                       result_stall,
	input  result_t                    result,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	output int                         mismatches,
	output int                         outstanding
);

	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] QUEUE_FULL = PTR_W'(QUEUE_DEPTH - 1);

	logic [BYTE_W-1:0] rx_mem [QUEUE_DEPTH];
	logic [BYTE_W-1:0] tx_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] rx_wr, rx_rd, tx_wr, tx_rd;
	logic peer_allows, we_allow;
	logic flow_on;
	logic [LEVEL_W-1:0] stop_lvl, resume_lvl;
	result_t awaited_results[$];
	result_t want;

	function automatic logic [PTR_W-1:0] rx_fill();
		return rx_wr - rx_rd;
	endfunction

	function automatic logic [PTR_W-1:0] tx_fill();
		return tx_wr - tx_rd;
	endfunction

	// control bytes jump the transmit queue
	function automatic bit push_control(logic [BYTE_W-1:0] code);
		if (tx_fill() == QUEUE_FULL)
			return 1'b0;
		tx_rd = tx_rd - 1'b1;
		tx_mem[tx_rd] = code;
		return 1'b1;
	endfunction

	function automatic result_t port_response(item_t req);
		result_t r;
		logic [PTR_W-1:0] occ;
		r = '0;
		case (req.action)
		ACT_LINE_RX: begin
			if (flow_on && req.data_byte == XON_BYTE)
				peer_allows = 1'b1;
			if (flow_on && req.data_byte == XOFF_BYTE)
				peer_allows = 1'b0;
			occ = rx_fill();
			if (occ != QUEUE_FULL) begin
				rx_mem[rx_wr] = req.data_byte;
				rx_wr = rx_wr + 1'b1;
				r.accepted = 1'b1;
			end
			if (flow_on && {1'b0, occ} > stop_lvl && we_allow) begin
				we_allow = 1'b0;
				if (!push_control(XOFF_BYTE))
					r.control_dropped = 1'b1;
			end
			if (flow_on && {1'b0, occ} < resume_lvl && !we_allow) begin
				we_allow = 1'b1;
				if (!push_control(XON_BYTE))
					r.control_dropped = 1'b1;
			end
		end
		ACT_HOST_SEND: begin
			if (tx_fill() != QUEUE_FULL) begin
				tx_mem[tx_wr] = req.data_byte;
				tx_wr = tx_wr + 1'b1;
				r.accepted = 1'b1;
			end
		end
		ACT_HOST_READ: begin
			if (rx_wr != rx_rd) begin
				r.host_byte = rx_mem[rx_rd];
				r.host_valid = 1'b1;
				rx_rd = rx_rd + 1'b1;
			end
		end
		default: begin
			if (tx_wr != tx_rd && (!flow_on || peer_allows)) begin
				r.line_byte = tx_mem[tx_rd];
				r.line_valid = 1'b1;
				tx_rd = tx_rd + 1'b1;
			end
		end
		endcase
		r.send_paused = flow_on && !peer_allows;
		r.rx_level = rx_fill();
		return r;
	endfunction

	task automatic compare_field(string name, int unsigned exp_val, int unsigned got_val);
		if (exp_val != got_val) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, exp_val, got_val);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wr = '0;
			rx_rd = '0;
			tx_wr = '0;
			tx_rd = '0;
			peer_allows = 1'b1;
			we_allow = 1'b1;
			flow_on = 1'b1;
			stop_lvl = STOP_LEVEL_RST;
			resume_lvl = RESUME_LEVEL_RST;
			awaited_results.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result with no request pending, got %h", $time, result);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					compare_field("line_valid", want.line_valid, result.line_valid);
					compare_field("line_byte", want.line_byte, result.line_byte);
					compare_field("host_valid", want.host_valid, result.host_valid);
					compare_field("host_byte", want.host_byte, result.host_byte);
					compare_field("accepted", want.accepted, result.accepted);
					compare_field("control_dropped", want.control_dropped,
						result.control_dropped);
					compare_field("send_paused", want.send_paused, result.send_paused);
					compare_field("rx_level", want.rx_level, result.rx_level);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
				CFG_FLOW_ENABLE: flow_on = cfg_data[0];
				CFG_STOP_LEVEL: stop_lvl = cfg_data;
				CFG_RESUME_LEVEL: resume_lvl = cfg_data;
				default: ;
				endcase
			end
			if (item_valid && !item_stall)
				awaited_results.push_back(port_response(item));
			outstanding <= awaited_results.size();
		end
	end

endmodule

// ===== bench/uart_fifo_xon_xoff_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_fifo_xon_xoff_tb
// Drives uart_fifo_xon_xoff with a short directed sequence covering the
// empty, paused and flow-off cases, then phases of random requests under
// several flow settings, biased in runs toward one kind of request so the
// queues fill, overflow and drain. Both sides idle at random; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module uart_fifo_xon_xoff_tb;
	import ufx_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int mismatches;
	int outstanding;
	bit sender_gaps;
	bit receiver_stalls;
	bit hold_off_req;

	always #5 clk = ~clk;

	uart_fifo_xon_xoff uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	uart_fifo_xon_xoff_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		#5_000_000;
		$display("uart_fifo_xon_xoff_tb: done, errors");
		$finish;
	end

	function automatic int idle_length();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [BYTE_W-1:0] line_data();
		case ($urandom_range(0, 7))
		0: return XON_BYTE;
		1: return XOFF_BYTE;
		default: return BYTE_W'($urandom());
		endcase
	endfunction

	task automatic offer(action_t act, logic [BYTE_W-1:0] data);
		int gap;
		item <= '{action: act, data_byte: data};
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		gap = (sender_gaps && $urandom_range(0, 3) == 0) ? idle_length() : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(bit flow, logic [CFG_DATA_W-1:0] stop,
			logic [CFG_DATA_W-1:0] resume);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FLOW_ENABLE;
		cfg_data <= CFG_DATA_W'(flow);
		@(posedge clk);
		cfg_index <= CFG_STOP_LEVEL;
		cfg_data <= stop;
		@(posedge clk);
		cfg_index <= CFG_RESUME_LEVEL;
		cfg_data <= resume;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// result side: random stalls plus one long hold-off on request
	initial begin
		result_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				result_stall <= 1'b1;
				repeat (200) @(posedge clk);
			end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat (idle_length()) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	initial begin
		int seg_left;
		action_t lead;
		action_t act;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_FLOW_ENABLE;
		cfg_data <= '0;
		sender_gaps = 1'b0;
		receiver_stalls = 1'b0;
		hold_off_req = 1'b0;
		seg_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queues, pause and resume by the partner
		offer(ACT_HOST_READ, 8'hFF);
		offer(ACT_LINE_READY, 8'h00);
		offer(ACT_HOST_SEND, 8'h00);
		offer(ACT_HOST_SEND, 8'hFF);
		offer(ACT_HOST_SEND, XOFF_BYTE);
		offer(ACT_LINE_RX, XOFF_BYTE);
		offer(ACT_LINE_READY, 8'h5A);
		offer(ACT_HOST_SEND, 8'hA5);
		offer(ACT_LINE_RX, XON_BYTE);
		offer(ACT_LINE_READY, 8'hFF);
		offer(ACT_LINE_READY, 8'h00);
		offer(ACT_LINE_RX, 8'h00);
		offer(ACT_LINE_RX, 8'hFF);
		offer(ACT_HOST_READ, 8'h00);
		offer(ACT_HOST_READ, 8'h00);
		offer(ACT_HOST_READ, 8'h00);
		offer(ACT_HOST_READ, 8'h00);
		offer(ACT_HOST_READ, 8'h00);
		settle();

		// flow off: control bytes are plain data
		load_settings(1'b0, 7'd64, 7'd0);
		offer(ACT_LINE_RX, XOFF_BYTE);
		offer(ACT_LINE_READY, 8'h00);
		offer(ACT_LINE_READY, 8'h00);
		offer(ACT_LINE_READY, 8'h00);
		offer(ACT_HOST_READ, 8'h00);
		settle();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
			0: load_settings(1'b1, 7'd48, 7'd16);
			1: load_settings(1'b1, 7'd0, 7'd64);
			2: load_settings(1'b1, 7'd64, 7'd0);
			3: load_settings(1'b0, 7'd40, 7'd20);
			4: load_settings(1'b1, 7'd8, 7'd4);
			5: load_settings(1'b1, CFG_DATA_W'($urandom_range(0, 127)),
				CFG_DATA_W'($urandom_range(0, 127)));
			6: load_settings(1'b1, 7'd62, 7'd63);
			default: load_settings(1'b1, 7'd32, 7'd31);
			endcase
			sender_gaps = (phase != 1) && ($urandom_range(0, 3) != 0);
			receiver_stalls = (phase != 1) && ($urandom_range(0, 3) != 0);
			if (phase == 2)
				hold_off_req = 1'b1;
			for (int n = 0; n < 100; n++) begin
				if (seg_left == 0) begin
					lead = action_t'($urandom_range(0, 3));
					seg_left = $urandom_range(20, 80);
				end
				seg_left--;
				act = ($urandom_range(0, 3) != 0) ? lead : action_t'($urandom_range(0, 3));
				offer(act, line_data());
			end
			settle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("uart_fifo_xon_xoff_tb: done, clean");
		else
			$display("uart_fifo_xon_xoff_tb: done, errors");
		$finish;
	end

endmodule
